FILE: rtl/bf3_pkg.sv
// Shared constants, types and result codes of the 3x3 clipped box filter.
`default_nettype none

package bf3_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SIZE_W   = 11;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 12;
    localparam int AVG_W    = 16;
    localparam int CFG_A_W  = 1;

    // floor(sum * 256 / 9) == (sum * RECIP) >> RECIP_SHIFT for every 12-bit sum.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1864136;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [SIZE_W-1:0] MAX_ROWS_SZ = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] MAX_COLS_SZ = SIZE_W'(MAX_COLS);

    typedef enum logic [CFG_A_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_reg_t;

    // Result kinds, in the order they leave for one pixel.
    typedef enum logic [1:0] {
        RES_UP_LEFT = 2'd0,
        RES_UP      = 2'd1,
        RES_LEFT    = 2'd2,
        RES_HERE    = 2'd3
    } res_kind_t;

    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    // One classified pixel: its window (cells outside the frame zeroed),
    // which results it causes, and its position.
    typedef struct packed {
        window_t          cells;
        logic [3:0]       mask;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/bf3_front.sv
// Front end: configuration, position counters, line store, window and classification.
`default_nettype none

module bf3_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bf3_pkg::CFG_A_W-1:0]       cfg_addr,
    input  wire logic [bf3_pkg::SIZE_W-1:0]        cfg_data,
    input  wire logic                              pix_valid,
    output logic                                   pix_ready,
    input  wire logic [bf3_pkg::PIX_W-1:0]         pixel,
    output logic                                   push,
    output bf3_pkg::entry_t                        push_entry,
    input  wire logic                              q_full
);

    localparam logic [bf3_pkg::SIZE_W-1:0] SIZE_W_ONE = bf3_pkg::SIZE_W'(1);

    logic [bf3_pkg::SIZE_W-1:0] num_rows_reg;
    logic [bf3_pkg::SIZE_W-1:0] num_cols_reg;
    logic [bf3_pkg::SIZE_W-1:0] rows_eff;
    logic [bf3_pkg::SIZE_W-1:0] cols_eff;

    logic [bf3_pkg::ROW_W-1:0] row_reg;
    logic [bf3_pkg::ROW_W-1:0] row_next;
    logic [bf3_pkg::COL_W-1:0] col_reg;
    logic [bf3_pkg::COL_W-1:0] col_next;
    logic                      last_col;
    logic                      last_row;

    logic                      a_valid_reg;
    logic [bf3_pkg::PIX_W-1:0] a_px_reg;
    logic [bf3_pkg::ROW_W-1:0] a_row_reg;
    logic [bf3_pkg::COL_W-1:0] a_col_reg;
    logic                      a_last_row_reg;
    logic                      a_last_col_reg;
    logic [2*bf3_pkg::PIX_W-1:0] rd_reg;

    logic [2*bf3_pkg::PIX_W-1:0] line_mem [bf3_pkg::MAX_COLS];
    logic [2*bf3_pkg::PIX_W-1:0] wr_data;

    logic [5:0][bf3_pkg::PIX_W-1:0] win_reg;
    bf3_pkg::window_t               win;
    logic [3:0]                     mask;
    logic                           accept;
    logic                           a_adv;
    logic                           row_ge1;
    logic                           row_ge2;
    logic                           col_ge1;
    logic                           col_ge2;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= bf3_pkg::MAX_ROWS_SZ;
            num_cols_reg <= bf3_pkg::MAX_COLS_SZ;
        end
        else if (cfg_we)
        begin
            unique case (bf3_pkg::cfg_reg_t'(cfg_addr))
                bf3_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                bf3_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero behaves as one; anything above the maximum as the maximum.
    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = SIZE_W_ONE;
        else if (num_rows_reg > bf3_pkg::MAX_ROWS_SZ)
            rows_eff = bf3_pkg::MAX_ROWS_SZ;
        else
            rows_eff = num_rows_reg;
        if (num_cols_reg == '0)
            cols_eff = SIZE_W_ONE;
        else if (num_cols_reg > bf3_pkg::MAX_COLS_SZ)
            cols_eff = bf3_pkg::MAX_COLS_SZ;
        else
            cols_eff = num_cols_reg;
    end

    assign a_adv     = a_valid_reg && ((mask == 4'b0) || !q_full);
    assign pix_ready = !a_valid_reg || a_adv;
    assign accept    = pix_valid && pix_ready;

    // Position of the incoming pixel and where the next one lands.
    always_comb
    begin
        last_col = (bf3_pkg::SIZE_W'(col_reg) + SIZE_W_ONE) >= cols_eff;
        last_row = (bf3_pkg::SIZE_W'(row_reg) + SIZE_W_ONE) >= rows_eff;
        col_next = col_reg + bf3_pkg::COL_W'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + bf3_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (pix_ready)
                a_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_px_reg       <= pixel;
            a_row_reg      <= row_reg;
            a_col_reg      <= col_reg;
            a_last_row_reg <= last_row;
            a_last_col_reg <= last_col;
        end
    end

    // Line store: upper byte is two rows up, lower byte the row above.
    assign wr_data = {rd_reg[bf3_pkg::PIX_W-1:0], a_px_reg};

    always_ff @(posedge clk)
    begin
        if (a_adv)
            line_mem[a_col_reg] <= wr_data;
        if (accept)
        begin
            // A one-column frame reads the column being written in the same cycle.
            if (a_adv && (a_col_reg == col_reg))
                rd_reg <= wr_data;
            else
                rd_reg <= line_mem[col_reg];
        end
    end

    always_comb
    begin
        win[0][0] = win_reg[0];
        win[0][1] = win_reg[1];
        win[1][0] = win_reg[2];
        win[1][1] = win_reg[3];
        win[2][0] = win_reg[4];
        win[2][1] = win_reg[5];
        win[0][2] = rd_reg[2*bf3_pkg::PIX_W-1:bf3_pkg::PIX_W];
        win[1][2] = rd_reg[bf3_pkg::PIX_W-1:0];
        win[2][2] = a_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (a_adv)
        begin
            win_reg[0] <= win[0][1];
            win_reg[1] <= win[0][2];
            win_reg[2] <= win[1][1];
            win_reg[3] <= win[1][2];
            win_reg[4] <= win[2][1];
            win_reg[5] <= win[2][2];
        end
    end

    // Classification: which results this pixel completes, and which window
    // cells lie inside the frame.
    always_comb
    begin
        row_ge1 = (a_row_reg != '0);
        row_ge2 = (a_row_reg[bf3_pkg::ROW_W-1:1] != '0);
        col_ge1 = (a_col_reg != '0);
        col_ge2 = (a_col_reg[bf3_pkg::COL_W-1:1] != '0);
        mask[bf3_pkg::RES_UP_LEFT] = row_ge1 && col_ge1;
        mask[bf3_pkg::RES_UP]      = row_ge1 && a_last_col_reg;
        mask[bf3_pkg::RES_LEFT]    = a_last_row_reg && col_ge1;
        mask[bf3_pkg::RES_HERE]    = a_last_row_reg && a_last_col_reg;
        push_entry.cells = win;
        if (!row_ge2)
            push_entry.cells[0] = '0;
        if (!row_ge1)
            push_entry.cells[1] = '0;
        if (!col_ge2)
        begin
            push_entry.cells[0][0] = '0;
            push_entry.cells[1][0] = '0;
            push_entry.cells[2][0] = '0;
        end
        if (!col_ge1)
        begin
            push_entry.cells[0][1] = '0;
            push_entry.cells[1][1] = '0;
            push_entry.cells[2][1] = '0;
        end
        push_entry.mask = mask;
        push_entry.row  = a_row_reg;
        push_entry.col  = a_col_reg;
    end

    assign push = a_adv && (mask != 4'b0);

endmodule

`default_nettype wire

FILE: rtl/bf3_queue.sv
// Short queue of classified pixels between the front and the back end.
`default_nettype none

module bf3_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bf3_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output bf3_pkg::entry_t      head_entry
);

    bf3_pkg::entry_t                 store_reg [bf3_pkg::Q_DEPTH];
    logic [bf3_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [bf3_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [bf3_pkg::Q_CNT_W-1:0]     count_reg;
    logic [bf3_pkg::Q_CNT_W-1:0]     count_next;

    assign full       = (count_reg == bf3_pkg::Q_CNT_W'(bf3_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + bf3_pkg::Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - bf3_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bf3_pkg::Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bf3_pkg::Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bf3_pkg::Q_CNT_W'(bf3_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: rtl/bf3_back.sv
// Back end: walks the results of each queued pixel, sums the window and divides by nine.
`default_nettype none

module bf3_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire bf3_pkg::entry_t               head_entry,
    output logic                               pop,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [bf3_pkg::ROW_W-1:0]          res_row,
    output logic [bf3_pkg::COL_W-1:0]          res_col,
    output logic [bf3_pkg::AVG_W-1:0]          res_avg,
    output logic                               res_last,
    output logic                               res_done
);

    logic [3:0]                 served_reg;
    logic [3:0]                 pending;
    logic [3:0]                 pick_bit;
    bf3_pkg::res_kind_t         kind;
    logic                       is_last;
    logic [bf3_pkg::SUM_W-1:0]  sum;

    logic                       s1_valid_reg;
    logic [bf3_pkg::SUM_W-1:0]  s1_sum_reg;
    logic [bf3_pkg::ROW_W-1:0]  s1_row_reg;
    logic [bf3_pkg::COL_W-1:0]  s1_col_reg;
    logic                       s1_last_reg;
    logic                       s1_done_reg;

    logic                       out_valid_reg;
    logic [bf3_pkg::ROW_W-1:0]  out_row_reg;
    logic [bf3_pkg::COL_W-1:0]  out_col_reg;
    logic [bf3_pkg::AVG_W-1:0]  out_avg_reg;
    logic                       out_last_reg;
    logic                       out_done_reg;

    logic                       out_free;
    logic                       s1_free;
    logic                       take;
    logic [bf3_pkg::PROD_W-1:0] product;

    assign pending = head_entry.mask & ~served_reg;

    // The lowest pending result goes first.
    always_comb
    begin
        if (pending[bf3_pkg::RES_UP_LEFT])
            kind = bf3_pkg::RES_UP_LEFT;
        else if (pending[bf3_pkg::RES_UP])
            kind = bf3_pkg::RES_UP;
        else if (pending[bf3_pkg::RES_LEFT])
            kind = bf3_pkg::RES_LEFT;
        else
            kind = bf3_pkg::RES_HERE;
        pick_bit = 4'b0001 << kind;
        is_last  = ((pending & ~pick_bit) == 4'b0);
    end

    // Window rows start one lower when the centre is on this row, and columns
    // one further right when the centre is on this column.
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                if ((k >= int'(kind[1])) && (m >= int'(kind[0])))
                    sum = sum + bf3_pkg::SUM_W'(head_entry.cells[k][m]);
            end
        end
    end

    assign out_free = !out_valid_reg || res_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign take     = head_valid && s1_free;
    assign pop      = take && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg    <= 4'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                served_reg <= is_last ? 4'b0 : (served_reg | pick_bit);
            if (s1_free)
                s1_valid_reg <= head_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sum_reg  <= sum;
            s1_row_reg  <= kind[1] ? head_entry.row : head_entry.row - bf3_pkg::ROW_W'(1);
            s1_col_reg  <= kind[0] ? head_entry.col : head_entry.col - bf3_pkg::COL_W'(1);
            s1_last_reg <= is_last;
            s1_done_reg <= (kind == bf3_pkg::RES_HERE);
        end
    end

    assign product = bf3_pkg::PROD_W'(s1_sum_reg) * bf3_pkg::PROD_W'(bf3_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_row_reg  <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
            out_avg_reg  <= product[bf3_pkg::RECIP_SHIFT +: bf3_pkg::AVG_W];
            out_last_reg <= s1_last_reg;
            out_done_reg <= s1_done_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_row   = out_row_reg;
    assign res_col   = out_col_reg;
    assign res_avg   = out_avg_reg;
    assign res_last  = out_last_reg;
    assign res_done  = out_done_reg;

    a_served_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((served_reg & ~head_entry.mask) == 4'b0))
        else $error("served result not in current pixel's set");

    a_served_clear_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (served_reg == 4'b0))
        else $error("served bits left over with no pixel waiting");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("frame end on a result that is not last of its run");

    a_take_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (pending != 4'b0))
        else $error("result taken from a pixel with nothing pending");

endmodule

`default_nettype wire

FILE: rtl/box_filter_3x3_clipped.sv
// Top level of the 3x3 clipped box filter over a raster pixel stream.
//
// Pixels enter on the s_ group in raster order, one per transaction, and the
// frame size is taken from two registers written on the cfg_ port while the
// block is idle (index 0 rows, index 1 columns; 0 counts as 1, sizes above
// 1024 count as 1024). Each pixel of the frame gets one result on the m_
// group: its row, column and the clipped 3x3 sum divided by nine as unsigned
// Q8.8. A result leaves once its window is complete; the pixel that completes
// it may release up to four, the last of which carries tlast, and the final
// result of the frame also carries tuser.
// A pixel is accepted every cycle while the queue has room; its results pass
// the pixel register, the queue, the sum stage and the output register. The
// rate is set by the back end, which turns out one result per cycle unless
// m_tready stalls it: within a row after the first the pixels release one
// result each on average (none at the first column, two at the last), which
// the queue absorbs, but in the last row each pixel after the first releases
// two and the final one four, so there the input is held off once the queue
// is full. A stall on m_tready fills the output register, the sum stage and
// the four-entry queue before s_tready falls.
// Reset empties the pipeline, sets both sizes to 1024 and restarts at row
// and column zero; the line store needs no clearing.
`default_nettype none

module box_filter_3x3_clipped
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bf3_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [bf3_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] pixel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [39:0]                        m_tdata,   // [9:0] out_row, [19:10] out_col,
                                                          // [35:20] average, [39:36] zero
    output logic                               m_tlast,   // last_of_run
    output logic                               m_tuser    // frame_done
);

    logic                            push;
    bf3_pkg::entry_t                 push_entry;
    logic                            q_full;
    logic                            pop;
    logic                            head_valid;
    bf3_pkg::entry_t                 head_entry;
    logic [bf3_pkg::ROW_W-1:0]       res_row;
    logic [bf3_pkg::COL_W-1:0]       res_col;
    logic [bf3_pkg::AVG_W-1:0]       res_avg;

    // Front end: counts the position, keeps two lines and the 3x3 window, and
    // decides which results each pixel completes.
    bf3_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pixel      (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // The queue lets the front keep taking pixels while several results of
    // one pixel drain out at the back.
    bf3_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back end: one result per cycle unless m_tready stalls it, sum stage then
    // reciprocal multiply into the output register.
    bf3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_avg    (res_avg),
        .res_last   (m_tlast),
        .res_done   (m_tuser)
    );

    assign m_tdata = {4'b0000, res_avg, res_col, res_row};

endmodule

`default_nettype wire
